FILE: rtl/sll_pkg.sv
// Shared types and codes for the static linked list engine.
// No dependencies; every other file of the block imports this package.
package sll_pkg;

  // Command codes.
  typedef enum logic [1:0] {
    OP_INS_HEAD = 2'd0,
    OP_INS_TAIL = 2'd1,
    OP_REMOVE   = 2'd2,
    OP_READ     = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INS_FREE,
    S_INS_TAKE,
    S_HEAD_LINK,
    S_HEAD_SET,
    S_TAIL_WALK,
    S_TAIL_SET,
    S_FIND,
    S_FOUND,
    S_REM_FREE,
    S_REM_SET
  } state_t;

  // Link memory read address source.
  typedef enum logic [1:0] {
    RA_DATA_HEAD,
    RA_FREE_HEAD,
    RA_LINK
  } rd_sel_t;

  // Link memory write address source.
  typedef enum logic [2:0] {
    WA_CLEAR,
    WA_DATA_HEAD,
    WA_FREE_HEAD,
    WA_NEWN,
    WA_PREV,
    WA_CUR
  } wa_sel_t;

  // Link memory write data source.
  typedef enum logic [2:0] {
    WD_CLEAR,
    WD_LINK,
    WD_ZERO,
    WD_NEWN,
    WD_CUR
  } wd_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;      // latch a new request, clear the result value
    logic    clr_step;    // advance the clearing pass
    rd_sel_t rd_sel;
    logic    wr_en;
    wa_sel_t wa_sel;
    wd_sel_t wd_sel;
    logic    load_newn;   // newly taken node <= link read data
    logic    load_cur;    // current node <= link read data
    logic    walk_start;  // predecessor <= data head sentinel, count <= 0
    logic    walk_step;   // predecessor <= link read data, count + 1
    logic    val_wr;      // value store write at the new node
    logic    val_capture; // result value <= value read data
    logic    res_valid;   // emit a result next cycle
    status_t res_status;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic link_zero;  // link read data is the end of a chain
    logic pos_hit;    // walk count equals the requested position
    logic clr_done;   // clearing pass is at the last entry
  } dp_stat_t;

endpackage

FILE: rtl/sll_datapath.sv
// Datapath of the static linked list engine: link and value memories,
// walk registers and result registers. Depends on sll_pkg.
module sll_datapath #(
  parameter int DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  sll_pkg::dp_cmd_t cmd,
  output sll_pkg::dp_stat_t stat,
  input  logic [1:0]       op,
  input  logic [31:0]      item_value,
  input  logic [7:0]       position,
  output logic             done,
  output logic [1:0]       status,
  output logic [31:0]      out_value
);
  import sll_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [AW-1:0] link_mem [DEPTH];
  logic [31:0]   value_mem [DEPTH];

  logic [AW-1:0] link_rdata;
  logic [31:0]   value_rdata;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] wr_data;

  logic [AW-1:0] clr_cnt;
  logic [AW-1:0] clr_value;
  logic [AW-1:0] newn;
  logic [AW-1:0] cur;
  logic [AW-1:0] prev;
  logic [7:0]    walk_cnt;
  op_t           op_q;
  logic [31:0]   item_q;
  logic [7:0]    pos_q;

  // Reset image of the link store: the data head sentinel and the last node end their chains.
  always_comb begin
    if ((clr_cnt == '0) || (clr_cnt == AW'(DEPTH - 1))) begin
      clr_value = '0;
    end else begin
      clr_value = clr_cnt + AW'(1);
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RA_DATA_HEAD: rd_addr = '0;
      RA_FREE_HEAD: rd_addr = AW'(1);
      RA_LINK:      rd_addr = link_rdata;
      default:      rd_addr = '0;
    endcase
  end

  always_comb begin
    case (cmd.wa_sel)
      WA_CLEAR:     wr_addr = clr_cnt;
      WA_DATA_HEAD: wr_addr = '0;
      WA_FREE_HEAD: wr_addr = AW'(1);
      WA_NEWN:      wr_addr = newn;
      WA_PREV:      wr_addr = prev;
      WA_CUR:       wr_addr = cur;
      default:      wr_addr = '0;
    endcase
  end

  always_comb begin
    case (cmd.wd_sel)
      WD_CLEAR: wr_data = clr_value;
      WD_LINK:  wr_data = link_rdata;
      WD_ZERO:  wr_data = '0;
      WD_NEWN:  wr_data = newn;
      WD_CUR:   wr_data = cur;
      default:  wr_data = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    link_rdata <= link_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.val_wr) begin
      value_mem[newn] <= item_q;
    end
    value_rdata <= value_mem[link_rdata];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q   <= op_t'(op);
      item_q <= item_value;
      pos_q  <= position;
    end
    if (cmd.load_newn) begin
      newn <= link_rdata;
    end
    if (cmd.load_cur) begin
      cur <= link_rdata;
    end
    if (cmd.walk_start) begin
      prev     <= '0;
      walk_cnt <= '0;
    end else if (cmd.walk_step) begin
      prev     <= link_rdata;
      walk_cnt <= walk_cnt + 8'd1;
    end
  end

  // The result value is zero unless a read or remove captured one.
  always_ff @(posedge clk) begin
    if (rst || cmd.accept) begin
      out_value <= '0;
    end else if (cmd.val_capture) begin
      out_value <= value_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done   <= 1'b0;
      status <= ST_OK;
    end else begin
      done <= cmd.res_valid;
      if (cmd.res_valid) begin
        status <= cmd.res_status;
      end
    end
  end

  assign stat.op        = op_q;
  assign stat.link_zero = (link_rdata == '0);
  assign stat.pos_hit   = (walk_cnt == pos_q);
  assign stat.clr_done  = (clr_cnt == AW'(DEPTH - 1));

endmodule

FILE: rtl/sll_ctrl.sv
// Controller state machine of the static linked list engine.
// Depends on sll_pkg; drives the datapath through dp_cmd_t.
module sll_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sll_pkg::dp_stat_t stat,
  output sll_pkg::dp_cmd_t  cmd
);
  import sll_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (stat.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_next = S_INS_FREE;
        end
      end
      S_INS_FREE: begin
        if (stat.op == OP_REMOVE || stat.op == OP_READ) begin
          state_next = S_FIND;
        end else if (stat.link_zero) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_INS_TAKE;
        end
      end
      S_INS_TAKE: begin
        if (stat.op == OP_INS_HEAD) begin
          state_next = S_HEAD_LINK;
        end else begin
          state_next = S_TAIL_WALK;
        end
      end
      S_HEAD_LINK: state_next = S_HEAD_SET;
      S_HEAD_SET:  state_next = S_IDLE;
      S_TAIL_WALK: begin
        if (stat.link_zero) begin
          state_next = S_TAIL_SET;
        end
      end
      S_TAIL_SET: state_next = S_IDLE;
      S_FIND: begin
        if (stat.link_zero) begin
          state_next = S_IDLE;
        end else if (stat.pos_hit) begin
          state_next = S_FOUND;
        end
      end
      S_FOUND: begin
        if (stat.op == OP_REMOVE) begin
          state_next = S_REM_FREE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_REM_FREE: state_next = S_REM_SET;
      S_REM_SET:  state_next = S_IDLE;
      default:    state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.rd_sel     = RA_DATA_HEAD;
    cmd.wa_sel     = WA_CLEAR;
    cmd.wd_sel     = WD_CLEAR;
    cmd.res_status = ST_OK;
    case (state)
      S_CLEAR: begin
        cmd.wr_en    = 1'b1;
        cmd.clr_step = 1'b1;
      end
      S_IDLE: begin
        // Only the free head is read here: the op is not
        // latched yet, so the free head is fetched and the data head is
        // fetched in S_INS_FREE for position requests.
        cmd.accept     = start;
        cmd.rd_sel     = RA_FREE_HEAD;
        cmd.walk_start = 1'b1;
      end
      S_INS_FREE: begin
        if (stat.op == OP_REMOVE || stat.op == OP_READ) begin
          cmd.rd_sel = RA_DATA_HEAD;
        end else if (stat.link_zero) begin
          cmd.res_valid  = 1'b1;
          cmd.res_status = ST_FULL;
        end else begin
          cmd.load_newn = 1'b1;
          cmd.rd_sel    = RA_LINK;
        end
      end
      S_INS_TAKE: begin
        cmd.wr_en      = 1'b1;
        cmd.wa_sel     = WA_FREE_HEAD;
        cmd.wd_sel     = WD_LINK;
        cmd.val_wr     = 1'b1;
        cmd.rd_sel     = RA_DATA_HEAD;
        cmd.walk_start = 1'b1;
      end
      S_HEAD_LINK: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = WA_NEWN;
        cmd.wd_sel = WD_LINK;
      end
      S_HEAD_SET: begin
        cmd.wr_en     = 1'b1;
        cmd.wa_sel    = WA_DATA_HEAD;
        cmd.wd_sel    = WD_NEWN;
        cmd.res_valid = 1'b1;
      end
      S_TAIL_WALK: begin
        if (stat.link_zero) begin
          cmd.wr_en  = 1'b1;
          cmd.wa_sel = WA_NEWN;
          cmd.wd_sel = WD_ZERO;
        end else begin
          cmd.walk_step = 1'b1;
          cmd.rd_sel    = RA_LINK;
        end
      end
      S_TAIL_SET: begin
        cmd.wr_en     = 1'b1;
        cmd.wa_sel    = WA_PREV;
        cmd.wd_sel    = WD_NEWN;
        cmd.res_valid = 1'b1;
      end
      S_FIND: begin
        if (stat.link_zero) begin
          cmd.res_valid  = 1'b1;
          cmd.res_status = ST_MISSING;
        end else if (stat.pos_hit) begin
          cmd.load_cur = 1'b1;
          cmd.rd_sel   = RA_LINK;
        end else begin
          cmd.walk_step = 1'b1;
          cmd.rd_sel    = RA_LINK;
        end
      end
      S_FOUND: begin
        cmd.val_capture = 1'b1;
        if (stat.op == OP_REMOVE) begin
          cmd.wr_en  = 1'b1;
          cmd.wa_sel = WA_PREV;
          cmd.wd_sel = WD_LINK;
          cmd.rd_sel = RA_FREE_HEAD;
        end else begin
          cmd.res_valid = 1'b1;
        end
      end
      S_REM_FREE: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = WA_CUR;
        cmd.wd_sel = WD_LINK;
      end
      S_REM_SET: begin
        cmd.wr_en     = 1'b1;
        cmd.wa_sel    = WA_FREE_HEAD;
        cmd.wd_sel    = WD_CUR;
        cmd.res_valid = 1'b1;
      end
      default: begin
        cmd.res_status = ST_OK;
      end
    endcase
  end

endmodule

FILE: rtl/static_linked_list_engine.sv
// Top level of the static linked list engine: controller plus datapath.
// Depends on sll_pkg, sll_ctrl and sll_datapath.
//
// The block keeps a linked list in a link memory of DEPTH entries, with entry 0
// as the head of the data list and entry 1 as the head of the free list. A
// request is taken at a clock edge where start is high and busy is low; its
// single result appears one cycle later than the last working state, with done
// high for exactly one cycle, and the receiver cannot stall it, so the result
// must be captured in that cycle. Busy stays high while a request is worked.
// The time per request is set by the link memory, which gives one link per
// cycle: insert at head needs no walk, insert at tail walks the whole list,
// read and remove walk to the requested position, a request for a position
// beyond the list walks all of it, and an insert with no free node ends once
// the free head is found empty. After reset the block first writes the
// free-list chain into the link memory, one entry per cycle, and holds busy
// high until the last entry is written. The values of removed nodes are not
// cleared, since they are rewritten before any later read can reach them.
module static_linked_list_engine #(
  parameter int DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic signed [31:0] item_value,
  input  logic [7:0]  position,
  output logic        done,
  output logic [1:0]  status,
  output logic signed [31:0] out_value
);
  import sll_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The state machine sequences the memory reads and writes of each request.
  sll_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // The datapath holds both memories and the walk pointers.
  sll_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .op         (op),
    .item_value (item_value),
    .position   (position),
    .done       (done),
    .status     (status),
    .out_value  (out_value)
  );

  // Failed requests never carry a value.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status != ST_OK) |-> out_value == '0)
    else $error("failed request returned a nonzero value");

  // An accepted request keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  // A result only follows a cycle of work.
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a request in work");

  // Results are single-cycle strobes.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  // Only an insert can report a full free list, and only a position request
  // can report a missing position; the assertion only checks that the status code is defined.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK) || (status == ST_FULL) || (status == ST_MISSING))
    else $error("undefined status code");

endmodule
